/* src/esdu_pkg.sv */
// Package for the event Sobel decay update block.
// Types, register codes, Sobel tap tables and the decay ROM; no dependencies.
package esdu_pkg;

  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROWS      = 256;
  localparam int DECAY_ENTRIES = 256;
  localparam int ADDR_W        = 16;
  localparam int GRAD_W        = 24;
  localparam int TIME_W        = 32;
  localparam int WORD_W        = TIME_W + 2 * GRAD_W;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [1:0] REG_ACTIVE_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ACTIVE_ROWS    = 2'd1;
  localparam logic [1:0] REG_STEP_WEIGHT    = 2'd2;
  localparam logic [1:0] REG_DECAY_SHIFT    = 2'd3;

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = 24'sh7FFFFF;
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = 24'sh800000;

  typedef logic signed [2:0] tap_t;
  typedef tap_t tap_rom_t [9];

  // neighbour k = u*3 + v (column-major); taps already reordered
  localparam tap_rom_t TAP_X = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                 3'sd1, 3'sd2, 3'sd1};
  localparam tap_rom_t TAP_Y = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2,
                                 -3'sd1, 3'sd0, 3'sd1};

  typedef logic [1:0] off_rom_t [9];
  localparam off_rom_t OFF_U = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam off_rom_t OFF_V = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

  typedef logic [15:0] decay_rom_t [DECAY_ENTRIES];

  function automatic decay_rom_t build_decay();
    decay_rom_t  r;
    logic [63:0] p;
    logic [63:0] q;
    p = 64'h1_0000_0000;
    for (int i = 0; i < DECAY_ENTRIES; i++) begin
      q    = (p + 64'd65536) >> 17;
      r[i] = q[15:0];
      p    = (p * 64'd4185842567 + 64'h8000_0000) >> 32;
    end
    return r;
  endfunction

  localparam decay_rom_t DECAY_TABLE = build_decay();

  typedef struct packed {
    logic [8:0]  active_columns;
    logic [8:0]  active_rows;
    logic [15:0] step_weight;
    logic [4:0]  decay_shift;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        col;
    logic [7:0]        row;
    logic [TIME_W-1:0] now;
    logic              on;
    tap_t              tap_x;
    tap_t              tap_y;
    logic              last;
  } job_t;

endpackage

/* src/esdu_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module esdu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/esdu_front.sv */
// Front end: accepts an event and issues its in-bounds neighbours as jobs.
// Uses esdu_pkg.
module esdu_front import esdu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        blocked,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);
  logic [8:0]        mask;
  logic [8:0]        mask_in;
  logic [7:0]        ev_col, ev_row;
  logic [TIME_W-1:0] ev_time;
  logic              ev_on;
  logic [3:0]        sel;
  logic [8:0]        rest;
  logic [9:0]        col_lim, row_lim;
  logic [9:0]        xs [3];
  logic [9:0]        ys [3];
  logic [2:0]        xok, yok;

  assign col_lim = (cfg.active_columns > 9'(MAX_COLUMNS)) ? 10'(MAX_COLUMNS)
                                                          : {1'b0, cfg.active_columns};
  assign row_lim = (cfg.active_rows > 9'(MAX_ROWS)) ? 10'(MAX_ROWS)
                                                    : {1'b0, cfg.active_rows};

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      xs[u]  = {2'b0, s_tdata[39:32]} + 10'(u) - 10'd1;
      ys[u]  = {2'b0, s_tdata[47:40]} + 10'(u) - 10'd1;
      xok[u] = !xs[u][9] && (xs[u] < col_lim);
      yok[u] = !ys[u][9] && (ys[u] < row_lim);
    end
    for (int k = 0; k < 9; k++) begin
      mask_in[k] = xok[k / 3] && yok[k % 3];
    end
  end

  always_comb begin
    sel = 4'd0;
    for (int k = 8; k >= 0; k--) begin
      if (mask[k]) begin
        sel = 4'(k);
      end
    end
    rest = mask & ~(9'd1 << sel);
  end

  assign s_tready  = !blocked && (mask == '0);
  assign job_valid = (mask != '0);

  always_comb begin
    job.col   = ev_col + 8'(OFF_U[sel]) - 8'd1;
    job.row   = ev_row + 8'(OFF_V[sel]) - 8'd1;
    job.now   = ev_time;
    job.on    = ev_on;
    job.tap_x = TAP_X[sel];
    job.tap_y = TAP_Y[sel];
    job.last  = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (s_tvalid && s_tready) begin
      mask <= mask_in;
    end else if (job_valid && job_ready) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ev_time <= s_tdata[31:0];
      ev_col  <= s_tdata[39:32];
      ev_row  <= s_tdata[47:40];
      ev_on   <= s_tdata[48];
    end
  end
endmodule

/* src/esdu_queue.sv */
// Short job queue between front and back end.
// Uses esdu_pkg.
module esdu_queue import esdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);
  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;
  logic          push, pop;

  assign push_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end
endmodule

/* src/esdu_back.sv */
// Back end: clears the pixel store, then per job reads, decays, adds and writes back.
// Uses esdu_pkg and esdu_ram.
module esdu_back import esdu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  output logic        clearing,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic        m_tlast
);
  logic [ADDR_W:0]   clr_cnt;
  logic              en, issue;
  logic              a_v, f_v, p_v;
  job_t              a_job, f_job, p_job;
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] job_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  logic signed [GRAD_W-1:0] f_oldx, f_oldy;
  logic [15:0]              f_factor;
  logic signed [40:0]       p_x, p_y;

  logic [TIME_W-1:0] old_time, dt, idx;
  logic [15:0]       factor;
  logic signed [GRAD_W-1:0] new_x, new_y;

  assign clearing = !clr_cnt[ADDR_W];
  assign job_addr = {job.row, job.col};
  assign en       = !m_tvalid || m_tready;

  assign issue = en && job_valid && !clearing
              && !(a_v && {a_job.row, a_job.col} == job_addr)
              && !(f_v && {f_job.row, f_job.col} == job_addr)
              && !(p_v && {p_job.row, p_job.col} == job_addr);
  assign job_ready = issue;

  esdu_ram #(.WIDTH(WORD_W), .DEPTH(MAX_COLUMNS * MAX_ROWS)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(job_addr),
    .rdata(rdata)
  );

  always_comb begin
    old_time = rdata[WORD_W-1 -: TIME_W];
    dt       = (a_job.now >= old_time) ? a_job.now - old_time : '0;
    idx      = dt >> cfg.decay_shift;
    factor   = (idx < TIME_W'(DECAY_ENTRIES)) ? DECAY_TABLE[idx[7:0]] : 16'd0;
  end

  function automatic logic signed [GRAD_W-1:0] finish(
    input logic signed [40:0] prod, input tap_t tap, input logic on,
    input logic [15:0] w);
    logic signed [40:0] t;
    logic signed [26:0] dec;
    logic signed [26:0] add;
    logic signed [26:0] sum;
    logic               neg;
    t   = prod + 41'sd16384;
    dec = 27'(t >>> 15);
    neg = tap[2] ^ !on;
    case (tap)
      3'sd1, -3'sd1: add = 27'({1'b0, w});
      3'sd2, -3'sd2: add = 27'({1'b0, w, 1'b0});
      default:       add = '0;
    endcase
    if (neg) begin
      add = -add;
    end
    sum = dec + add;
    if (sum > 27'(GRAD_MAX)) begin
      return GRAD_MAX;
    end else if (sum < 27'(GRAD_MIN)) begin
      return GRAD_MIN;
    end
    return sum[GRAD_W-1:0];
  endfunction

  assign new_x = finish(p_x, p_job.tap_x, p_job.on, cfg.step_weight);
  assign new_y = finish(p_y, p_job.tap_y, p_job.on, cfg.step_weight);

  always_comb begin
    if (clearing) begin
      ram_we = 1'b1;
      waddr  = clr_cnt[ADDR_W-1:0];
      wdata  = '0;
    end else begin
      ram_we = en && p_v;
      waddr  = {p_job.row, p_job.col};
      wdata  = {p_job.now, new_y, new_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      a_v      <= 1'b0;
      f_v      <= 1'b0;
      p_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (en) begin
        a_v      <= issue;
        f_v      <= a_v;
        p_v      <= f_v;
        m_tvalid <= p_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_job    <= job;
      f_job    <= a_job;
      f_oldx   <= rdata[GRAD_W-1:0];
      f_oldy   <= rdata[2*GRAD_W-1:GRAD_W];
      f_factor <= factor;
      p_job    <= f_job;
      p_x      <= f_oldx * $signed({1'b0, f_factor});
      p_y      <= f_oldy * $signed({1'b0, f_factor});
      m_tdata  <= {new_y, new_x, p_job.row, p_job.col};
      m_tlast  <= p_job.last;
    end
  end
endmodule

/* src/event_sobel_decay_update_top.sv */
// The front end takes an event, then issues one in-bounds neighbour a cycle
// (nine for an interior event) while the queue has room, and takes no new
// event until the last is issued; the back end works one neighbour a cycle,
// unless the output stalls, through a four-stage read-modify-write pipeline
// on one store RAM and stalls a neighbour whose pixel is still in flight.
// After reset a clearing pass zeroes all 65536 store words, and no event is
// accepted until it ends. Results pass the event register, queue and pipeline.
module event_sobel_decay_update_top import esdu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // event_time, event_col, event_row, event_on
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // pixel_col, pixel_row, gradient_x, gradient_y
  output logic        m_tlast
);
  cfg_t cfg;
  logic clearing;
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_columns <= 9'd240;
      cfg.active_rows    <= 9'd180;
      cfg.step_weight    <= 16'd6554;
      cfg.decay_shift    <= 5'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_COLUMNS: cfg.active_columns <= cfg_data[8:0];
        REG_ACTIVE_ROWS:    cfg.active_rows    <= cfg_data[8:0];
        REG_STEP_WEIGHT:    cfg.step_weight    <= cfg_data;
        REG_DECAY_SHIFT:    cfg.decay_shift    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  esdu_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .blocked(clearing),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  esdu_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_job(f_job),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_job(q_job)
  );

  esdu_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .clearing(clearing),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule

/* src/esdu_checker.sv */
// Port-level checks for the top level, bound to it below.
// Depends on event_sobel_decay_update_top.
module esdu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("event accepted during store clear");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("word shown straight after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled word changed");
endmodule

bind event_sobel_decay_update_top esdu_checker u_esdu_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
